// ----- design/aee_pkg.sv -----
// Package for the arithmetic expression evaluator: types, constants and
// fixed-point helper functions. It depends on nothing.
package aee_pkg;

   localparam int unsigned FDIG_W      = 5;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MANT_LIMIT = 64'd1844674407370955160;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_BAD_CHAR = 3'd1,
      STATUS_TWO_DOTS = 3'd2,
      STATUS_DIV_ZERO = 3'd3,
      STATUS_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_DOT,
      KIND_MULDIV,
      KIND_ADDSUB,
      KIND_BAD
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CONV_START,
      S_CONV_WAIT,
      S_FACTOR,
      S_MUL,
      S_MUL_DONE,
      S_DIV_START,
      S_DIV_WAIT,
      S_POST,
      S_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      AFTER_MULDIV,
      AFTER_ADDSUB,
      AFTER_FINAL
   } after_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       alt_op;
      logic       is_last;
   } entry_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [2:0]         status;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_flags_type;

   typedef struct packed {
      logic [63:0] value;
      logic        ovf;
   } sat_type;

   function automatic logic [63:0] magnitude(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   function automatic sat_type saturate(input logic neg, input logic hi_nz,
                                        input logic [63:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (!neg) begin
         if (hi_nz || (mag > MAX_POS)) begin
            r.value = MAX_POS;
            r.ovf   = 1'b1;
         end else begin
            r.value = mag;
         end
      end else begin
         if (hi_nz || (mag > SIGN_BIT)) begin
            r.value = SIGN_BIT;
            r.ovf   = 1'b1;
         end else begin
            r.value = 64'd0 - mag;
         end
      end
      return r;
   endfunction

   function automatic sat_type fx_add(input logic [63:0] a, input logic [63:0] b,
                                      input logic subtract);
      sat_type     r;
      logic [63:0] same;
      r.value = subtract ? (a - b) : (a + b);
      same    = subtract ? (a ^ b) : ~(a ^ b);
      r.ovf   = ((same & (a ^ r.value) & SIGN_BIT) != 64'd0);
      if (r.ovf) begin
         r.value = a[63] ? SIGN_BIT : MAX_POS;
      end
      return r;
   endfunction

   // Keeps the smallest nonzero status code.
   function automatic status_type note(input status_type cur, input status_type code);
      return ((cur == STATUS_OK) || (code < cur)) ? code : cur;
   endfunction

   function automatic logic [63:0] pow10(input logic [FDIG_W-1:0] n);
      logic [63:0] p;
      case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         default: p = 64'd1000000000000000000;
      endcase
      return p;
   endfunction

endpackage

// ----- design/aee_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
// Depends on nothing; users pass one of the payload types of aee_pkg.
interface aee_stream_if #(parameter type payload_type = logic [7:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/aee_front.sv -----
// Front end: takes characters from the request channel and classifies them
// into queue entries. Depends on aee_pkg and aee_stream_if.
module aee_front (
   aee_stream_if.sink         req,
   input  logic               full,
   output logic               push,
   output aee_pkg::entry_type entry
);

   logic [7:0] c;

   assign c         = req.payload.char_code;
   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      entry.digit   = c[3:0];
      entry.is_last = req.payload.is_last;
      entry.alt_op  = (c == aee_pkg::CHAR_SLASH) || (c == aee_pkg::CHAR_MINUS);
      case (c) inside
         [aee_pkg::CHAR_0:aee_pkg::CHAR_9]:           entry.kind = aee_pkg::KIND_DIGIT;
         aee_pkg::CHAR_DOT:                           entry.kind = aee_pkg::KIND_DOT;
         aee_pkg::CHAR_STAR, aee_pkg::CHAR_SLASH:     entry.kind = aee_pkg::KIND_MULDIV;
         aee_pkg::CHAR_PLUS, aee_pkg::CHAR_MINUS:     entry.kind = aee_pkg::KIND_ADDSUB;
         default:                                     entry.kind = aee_pkg::KIND_BAD;
      endcase
   end

endmodule

// ----- design/aee_queue.sv -----
// Short FIFO of classified characters between front and back end.
// Depends on aee_pkg.
module aee_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aee_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output aee_pkg::entry_type pop_entry,
   output logic               not_empty
);

   aee_pkg::entry_type                 slots_ff [aee_pkg::QUEUE_DEPTH];
   logic [aee_pkg::PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [aee_pkg::PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [aee_pkg::CNT_W-1:0]          count_ff, count_in;

   assign full      = (count_ff == aee_pkg::CNT_W'(aee_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + aee_pkg::CNT_W'(push) - aee_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/aee_divider.sv -----
// Restoring divider, one quotient bit per cycle over a 128-bit dividend.
// Depends on aee_pkg.
module aee_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [127:0]           numer,
   input  logic [63:0]            denom,
   output aee_pkg::div_flags_type flags,
   output logic [127:0]           quot,
   output logic [63:0]            rem
);

   logic [127:0] numer_ff, numer_in;
   logic [127:0] quot_ff, quot_in;
   logic [63:0]  rem_ff, rem_in;
   logic [63:0]  denom_ff, denom_in;
   logic [6:0]   count_ff, count_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [64:0]  trial;
   logic         fits;

   assign trial       = {rem_ff, numer_ff[127]};
   assign fits        = (trial >= {1'b0, denom_ff});
   assign flags.busy  = busy_ff;
   assign flags.done  = done_ff;
   assign quot        = quot_ff;
   assign rem         = rem_ff;

   always_comb begin
      numer_in = numer_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         numer_in = numer;
         denom_in = denom;
         quot_in  = '0;
         rem_in   = '0;
         count_in = 7'd127;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so 64 bits always hold it.
         rem_in   = fits ? 64'(trial - {1'b0, denom_ff}) : trial[63:0];
         quot_in  = {quot_ff[126:0], fits};
         numer_in = {numer_ff[126:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      numer_ff <= numer_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
   end

endmodule

// ----- design/aee_back.sv -----
// Back end: runs the evaluation state, number conversion, the iterative
// multiply and divide, and drives the result channel.
// Depends on aee_pkg, aee_stream_if and aee_divider.
module aee_back #(
   parameter int FRAC_BITS  = 32,
   parameter int MAX_DIGITS = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               entry_valid,
   input  aee_pkg::entry_type entry,
   output logic               pop,
   aee_stream_if.source       rsp
);

   localparam logic [aee_pkg::FDIG_W-1:0] MAX_FDIG = aee_pkg::FDIG_W'(MAX_DIGITS);
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

   aee_pkg::back_state_type state_ff, state_in;
   aee_pkg::after_type      after_ff, after_in;
   aee_pkg::entry_type      item_ff, item_in;
   aee_pkg::status_type     err_ff, err_in;
   logic [63:0]             sum_ff, sum_in;
   logic [63:0]             prod_ff, prod_in;
   logic [63:0]             mant_ff, mant_in;
   logic [aee_pkg::FDIG_W-1:0] fdig_ff, fdig_in;
   logic                    dot_ff, dot_in;
   logic                    pdiv_ff, pdiv_in;
   logic                    neg_ff, neg_in;
   logic                    tstart_ff, tstart_in;
   logic [63:0]             q_ff, q_in;
   logic [127:0]            acc_ff, acc_in;
   logic [1:0]              mul_idx_ff, mul_idx_in;
   logic [63:0]             ma_ff, ma_in;
   logic [63:0]             mb_ff, mb_in;
   logic                    mneg_ff, mneg_in;
   logic [63:0]             out_value_ff, out_value_in;
   logic [2:0]              out_status_ff, out_status_in;

   logic                    div_start;
   logic [127:0]            div_numer;
   logic [63:0]             div_denom;
   aee_pkg::div_flags_type  div_flags;
   logic [127:0]            div_quot;
   logic [63:0]             div_rem;

   logic [63:0]             p10;
   logic [63:0]             mant_x10;
   logic [127:0]            qfull;
   logic                    round_up;
   logic [63:0]             qval;
   logic                    qovf;
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [63:0]             mul_pp;
   logic [6:0]              mul_sh;
   aee_pkg::sat_type        mul_sat;
   aee_pkg::sat_type        div_sat;
   aee_pkg::sat_type        add_sat;
   logic                    rsp_fire;

   aee_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .flags (div_flags),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign p10      = aee_pkg::pow10(fdig_ff);
   assign mant_x10 = (mant_ff << 3) + (mant_ff << 1) + {60'd0, entry.digit};
   assign round_up = ({div_rem, 1'b0} >= {1'b0, p10});
   assign qfull    = div_quot + {127'd0, round_up};
   assign qovf     = (qfull[127:63] != '0);
   assign qval     = qovf ? aee_pkg::MAX_POS : qfull[63:0];
   assign mul_a    = mul_idx_ff[0] ? ma_ff[63:32] : ma_ff[31:0];
   assign mul_b    = mul_idx_ff[1] ? mb_ff[63:32] : mb_ff[31:0];
   assign mul_pp   = mul_a * mul_b;
   assign mul_sh   = {({1'b0, mul_idx_ff[0]} + {1'b0, mul_idx_ff[1]}), 5'b0};
   assign mul_sat  = aee_pkg::saturate(mneg_ff, (acc_ff[127:64+FRAC_BITS] != '0),
                                       acc_ff[63+FRAC_BITS:FRAC_BITS]);
   assign div_sat  = aee_pkg::saturate(prod_ff[63] ^ q_ff[63], (div_quot[127:64] != '0),
                                       div_quot[63:0]);
   assign add_sat  = aee_pkg::fx_add(sum_ff, prod_ff, neg_ff);
   assign rsp_fire = rsp.valid && rsp.ready;

   assign rsp.valid          = (state_ff == aee_pkg::S_OUT);
   assign rsp.payload.value  = out_value_ff;
   assign rsp.payload.status = out_status_ff;

   // Divider operands: number conversion or a fixed-point quotient.
   always_comb begin
      div_start = (state_ff == aee_pkg::S_CONV_START) || (state_ff == aee_pkg::S_DIV_START);
      if (state_ff == aee_pkg::S_DIV_START) begin
         div_numer = {64'd0, aee_pkg::magnitude(prod_ff)} << FRAC_BITS;
         div_denom = aee_pkg::magnitude(q_ff);
      end else begin
         div_numer = {64'd0, mant_ff} << FRAC_BITS;
         div_denom = p10;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aee_pkg::S_IDLE: begin
            if (entry_valid) begin
               if ((entry.kind == aee_pkg::KIND_ADDSUB) || entry.is_last ||
                   ((entry.kind == aee_pkg::KIND_MULDIV) && !tstart_ff)) begin
                  state_in = aee_pkg::S_CONV_START;
               end
            end
         end
         aee_pkg::S_CONV_START: state_in = aee_pkg::S_CONV_WAIT;
         aee_pkg::S_CONV_WAIT: begin
            if (div_flags.done) begin
               state_in = aee_pkg::S_FACTOR;
            end
         end
         aee_pkg::S_FACTOR: begin
            if (!pdiv_ff) begin
               state_in = aee_pkg::S_MUL;
            end else if (qval == '0) begin
               state_in = aee_pkg::S_POST;
            end else begin
               state_in = aee_pkg::S_DIV_START;
            end
         end
         aee_pkg::S_MUL: begin
            if (mul_idx_ff == 2'd3) begin
               state_in = aee_pkg::S_MUL_DONE;
            end
         end
         aee_pkg::S_MUL_DONE:  state_in = aee_pkg::S_POST;
         aee_pkg::S_DIV_START: state_in = aee_pkg::S_DIV_WAIT;
         aee_pkg::S_DIV_WAIT: begin
            if (div_flags.done) begin
               state_in = aee_pkg::S_POST;
            end
         end
         aee_pkg::S_POST: begin
            if (after_ff == aee_pkg::AFTER_FINAL) begin
               state_in = aee_pkg::S_OUT;
            end else if (item_ff.is_last) begin
               state_in = aee_pkg::S_CONV_START;
            end else begin
               state_in = aee_pkg::S_IDLE;
            end
         end
         aee_pkg::S_OUT: begin
            if (rsp_fire) begin
               state_in = aee_pkg::S_IDLE;
            end
         end
         default: state_in = aee_pkg::S_IDLE;
      endcase
   end

   // Datapath and evaluation state.
   always_comb begin
      pop           = 1'b0;
      after_in      = after_ff;
      item_in       = item_ff;
      err_in        = err_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      mant_in       = mant_ff;
      fdig_in       = fdig_ff;
      dot_in        = dot_ff;
      pdiv_in       = pdiv_ff;
      neg_in        = neg_ff;
      tstart_in     = tstart_ff;
      q_in          = q_ff;
      acc_in        = acc_ff;
      mul_idx_in    = mul_idx_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      mneg_in       = mneg_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      case (state_ff)
         aee_pkg::S_IDLE: begin
            if (entry_valid) begin
               pop     = 1'b1;
               item_in = entry;
               if (entry.is_last) begin
                  after_in = aee_pkg::AFTER_FINAL;
               end
               case (entry.kind)
                  aee_pkg::KIND_DIGIT: begin
                     tstart_in = 1'b0;
                     if (dot_ff) begin
                        if ((fdig_ff < MAX_FDIG) && (mant_ff <= aee_pkg::MANT_LIMIT)) begin
                           mant_in = mant_x10;
                           fdig_in = fdig_ff + 1'b1;
                        end
                     end else if (mant_ff > aee_pkg::MANT_LIMIT) begin
                        mant_in = '1;
                     end else begin
                        mant_in = mant_x10;
                     end
                  end
                  aee_pkg::KIND_DOT: begin
                     tstart_in = 1'b0;
                     if (dot_ff) begin
                        err_in = aee_pkg::note(err_ff, aee_pkg::STATUS_TWO_DOTS);
                     end else begin
                        dot_in = 1'b1;
                     end
                  end
                  aee_pkg::KIND_MULDIV: begin
                     if (!tstart_ff) begin
                        after_in = aee_pkg::AFTER_MULDIV;
                     end else begin
                        // A leading operator of a term applies to 1.0.
                        tstart_in = 1'b0;
                        pdiv_in   = entry.alt_op;
                     end
                  end
                  aee_pkg::KIND_ADDSUB: after_in = aee_pkg::AFTER_ADDSUB;
                  default: err_in = aee_pkg::note(err_ff, aee_pkg::STATUS_BAD_CHAR);
               endcase
            end
         end
         aee_pkg::S_FACTOR: begin
            q_in = qval;
            if (qovf) begin
               err_in = aee_pkg::note(err_ff, aee_pkg::STATUS_OVERFLOW);
            end
            if (pdiv_ff && (qval == '0)) begin
               err_in  = aee_pkg::note(err_ff, aee_pkg::STATUS_DIV_ZERO);
               prod_in = '0;
            end
            ma_in      = aee_pkg::magnitude(prod_ff);
            mb_in      = aee_pkg::magnitude(qval);
            mneg_in    = prod_ff[63] ^ qval[63];
            acc_in     = '0;
            mul_idx_in = '0;
         end
         aee_pkg::S_MUL: begin
            acc_in     = acc_ff + ({64'd0, mul_pp} << mul_sh);
            mul_idx_in = mul_idx_ff + 1'b1;
         end
         aee_pkg::S_MUL_DONE: begin
            prod_in = mul_sat.value;
            if (mul_sat.ovf) begin
               err_in = aee_pkg::note(err_ff, aee_pkg::STATUS_OVERFLOW);
            end
         end
         aee_pkg::S_DIV_WAIT: begin
            if (div_flags.done) begin
               prod_in = div_sat.value;
               if (div_sat.ovf) begin
                  err_in = aee_pkg::note(err_ff, aee_pkg::STATUS_OVERFLOW);
               end
            end
         end
         aee_pkg::S_POST: begin
            mant_in = '0;
            fdig_in = '0;
            dot_in  = 1'b0;
            if (after_ff == aee_pkg::AFTER_MULDIV) begin
               pdiv_in   = item_ff.alt_op;
               tstart_in = 1'b0;
            end else begin
               sum_in    = add_sat.value;
               if (add_sat.ovf) begin
                  err_in = aee_pkg::note(err_ff, aee_pkg::STATUS_OVERFLOW);
               end
               prod_in   = ONE;
               pdiv_in   = 1'b0;
               tstart_in = 1'b1;
               if (after_ff == aee_pkg::AFTER_ADDSUB) begin
                  neg_in = item_ff.alt_op;
               end
            end
            if (after_ff == aee_pkg::AFTER_FINAL) begin
               out_status_in = err_in;
               out_value_in  = ((err_in == aee_pkg::STATUS_BAD_CHAR) ||
                                (err_in == aee_pkg::STATUS_TWO_DOTS) ||
                                (err_in == aee_pkg::STATUS_DIV_ZERO)) ? '0 : sum_in;
            end else if (item_ff.is_last) begin
               after_in = aee_pkg::AFTER_FINAL;
            end
         end
         aee_pkg::S_OUT: begin
            if (rsp_fire) begin
               sum_in    = '0;
               prod_in   = ONE;
               mant_in   = '0;
               fdig_in   = '0;
               dot_in    = 1'b0;
               pdiv_in   = 1'b0;
               neg_in    = 1'b0;
               tstart_in = 1'b1;
               err_in    = aee_pkg::STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= aee_pkg::S_IDLE;
         after_ff  <= aee_pkg::AFTER_MULDIV;
         err_ff    <= aee_pkg::STATUS_OK;
         sum_ff    <= '0;
         prod_ff   <= ONE;
         mant_ff   <= '0;
         fdig_ff   <= '0;
         dot_ff    <= 1'b0;
         pdiv_ff   <= 1'b0;
         neg_ff    <= 1'b0;
         tstart_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         after_ff  <= after_in;
         err_ff    <= err_in;
         sum_ff    <= sum_in;
         prod_ff   <= prod_in;
         mant_ff   <= mant_in;
         fdig_ff   <= fdig_in;
         dot_ff    <= dot_in;
         pdiv_ff   <= pdiv_in;
         neg_ff    <= neg_in;
         tstart_ff <= tstart_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      q_ff          <= q_in;
      acc_ff        <= acc_in;
      mul_idx_ff    <= mul_idx_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      mneg_ff       <= mneg_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

`ifndef NO_ASSERTIONS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_flags.busy)
      else $error("divider started while busy");

   a_div_wait_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aee_pkg::S_DIV_WAIT || state_ff == aee_pkg::S_CONV_WAIT)
      |-> (div_flags.busy || div_flags.done))
      else $error("waiting on an idle divider");

   a_fdig_bound: assert property (@(posedge clock) disable iff (reset)
      fdig_ff <= MAX_FDIG)
      else $error("fraction digit count above limit");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> (sum_ff == '0) && tstart_ff && (err_ff == aee_pkg::STATUS_OK))
      else $error("state not cleared after result transfer");
`endif

endmodule

// ----- design/arith_expression_evaluator_top.sv -----
// A digit, dot or bad character is popped and retired while the back end is idle.
// An operator (but a * or / that leads a term) converts the pending number on a 128-step
// bit-serial divider, then multiplies by partial products or divides on it, and closes the term.
// The last character adds one more term close; the result holds until taken.
// Throughput is set by the shared divider; a 4-entry queue buffers input.
// Reset is synchronous, active high, and returns the evaluator to 0 with term start.
module arith_expression_evaluator_top #(
   parameter int FRAC_BITS  = 32,
   parameter int MAX_DIGITS = 18
) (
   input logic          clock,
   input logic          reset,
   aee_stream_if.sink   req_chan,
   aee_stream_if.source rsp_chan
);

   logic               push;
   logic               full;
   logic               pop;
   logic               not_empty;
   aee_pkg::entry_type push_entry;
   aee_pkg::entry_type pop_entry;

   aee_front u_front (
      .req   (req_chan),
      .full  (full),
      .push  (push),
      .entry (push_entry)
   );

   aee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (not_empty)
   );

   aee_back #(
      .FRAC_BITS  (FRAC_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (not_empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for arith_expression_evaluator_top: it streams ASCII
// expressions and checks each value and status against an in-bench predictor.
// Depends on aee_pkg and aee_stream_if from the design folder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 1500;
   localparam logic [63:0] ONE_Q = 64'h1_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   aee_stream_if #(.payload_type(aee_pkg::req_payload_type)) req_if ();
   aee_stream_if #(.payload_type(aee_pkg::rsp_payload_type)) rsp_if ();

   arith_expression_evaluator_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   typedef struct {
      logic [63:0]         value;
      aee_pkg::status_type status;
   } expected_result_type;

   expected_result_type pending_results[$];
   int  error_count = 0;
   bit  quiet = 1'b0;
   bit  long_hold_pending = 1'b0;
   int  items_sent = 0;

   // Evaluator state as the predictor sees it.
   logic [63:0] sum_q, prod_q, mant;
   int unsigned frac_cnt;
   bit          dot_on, div_pending, minus_term, term_start;
   aee_pkg::status_type err;

   function automatic void clear_state();
      sum_q = 0; prod_q = ONE_Q; mant = 0; frac_cnt = 0;
      dot_on = 0; div_pending = 0; minus_term = 0; term_start = 1;
      err = aee_pkg::STATUS_OK;
   endfunction

   function automatic void flag(aee_pkg::status_type code);
      if (err == aee_pkg::STATUS_OK || code < err) err = code;
   endfunction

   function automatic logic [63:0] clamp(bit neg, bit hi_nz, logic [63:0] mag);
      if (!neg) begin
         if (hi_nz || mag > aee_pkg::MAX_POS) begin
            flag(aee_pkg::STATUS_OVERFLOW);
            return aee_pkg::MAX_POS;
         end
         return mag;
      end
      if (hi_nz || mag > aee_pkg::SIGN_BIT) begin
         flag(aee_pkg::STATUS_OVERFLOW);
         return aee_pkg::SIGN_BIT;
      end
      return -mag;
   endfunction

   function automatic logic [63:0] abs64(logic [63:0] x);
      return x[63] ? -x : x;
   endfunction

   // Decimal digits to Q31.32, rounded to nearest with halves up.
   function automatic logic [63:0] to_fixed();
      logic [127:0] scale, ip, rem, frac, q;
      scale = 1;
      for (int i = 0; i < frac_cnt && i < 18; i++) scale = scale * 10;
      ip   = mant / scale;
      rem  = mant % scale;
      frac = ((rem << 33) + scale) / (scale << 1);
      if (ip > (aee_pkg::MAX_POS >> 32)) begin
         flag(aee_pkg::STATUS_OVERFLOW);
         return aee_pkg::MAX_POS;
      end
      q = (ip << 32) + frac;
      if (q > aee_pkg::MAX_POS) begin
         flag(aee_pkg::STATUS_OVERFLOW);
         return aee_pkg::MAX_POS;
      end
      return q[63:0];
   endfunction

   function automatic void take_factor();
      logic [63:0]  q, ma, mb;
      logic [127:0] wide;
      bit           neg;
      q   = to_fixed();
      ma  = abs64(prod_q);
      mb  = abs64(q);
      neg = prod_q[63] ^ q[63];
      if (div_pending) begin
         if (q == 0) begin
            flag(aee_pkg::STATUS_DIV_ZERO);
            prod_q = 0;
         end else begin
            wide   = ({64'd0, ma} << 32) / {64'd0, mb};
            prod_q = clamp(neg, wide[127:64] != 0, wide[63:0]);
         end
      end else begin
         wide   = {64'd0, ma} * {64'd0, mb};
         prod_q = clamp(neg, wide[127:96] != 0, wide[95:32]);
      end
      mant = 0; frac_cnt = 0; dot_on = 0;
   endfunction

   function automatic void end_term();
      logic signed [64:0] s;
      take_factor();
      s = minus_term ? $signed({sum_q[63], sum_q}) - $signed({prod_q[63], prod_q})
                     : $signed({sum_q[63], sum_q}) + $signed({prod_q[63], prod_q});
      if (s[64] != s[63]) begin
         flag(aee_pkg::STATUS_OVERFLOW);
         sum_q = s[64] ? aee_pkg::SIGN_BIT : aee_pkg::MAX_POS;
      end else begin
         sum_q = s[63:0];
      end
      prod_q = ONE_Q; div_pending = 0; term_start = 1;
   endfunction

   function automatic void predict_char(logic [7:0] c, bit last);
      expected_result_type r;
      if (c >= aee_pkg::CHAR_0 && c <= aee_pkg::CHAR_9) begin
         term_start = 0;
         if (dot_on) begin
            if (frac_cnt < 18 && mant <= aee_pkg::MANT_LIMIT) begin
               mant = mant * 10 + (c - aee_pkg::CHAR_0);
               frac_cnt++;
            end
         end else if (mant > aee_pkg::MANT_LIMIT) begin
            mant = '1;
         end else begin
            mant = mant * 10 + (c - aee_pkg::CHAR_0);
         end
      end else if (c == aee_pkg::CHAR_DOT) begin
         term_start = 0;
         if (dot_on) flag(aee_pkg::STATUS_TWO_DOTS);
         else dot_on = 1;
      end else if (c == aee_pkg::CHAR_STAR || c == aee_pkg::CHAR_SLASH) begin
         if (!term_start) take_factor();
         term_start = 0;
         div_pending = (c == aee_pkg::CHAR_SLASH);
      end else if (c == aee_pkg::CHAR_PLUS || c == aee_pkg::CHAR_MINUS) begin
         end_term();
         minus_term = (c == aee_pkg::CHAR_MINUS);
      end else begin
         flag(aee_pkg::STATUS_BAD_CHAR);
      end
      if (last) begin
         end_term();
         r.status = err;
         r.value  = (err == aee_pkg::STATUS_BAD_CHAR || err == aee_pkg::STATUS_TWO_DOTS ||
                     err == aee_pkg::STATUS_DIV_ZERO) ? 64'd0 : sum_q;
         pending_results.push_back(r);
         clear_state();
      end
   endfunction

   // One character transfer; the valid stays up between back-to-back transfers.
   task automatic send_char(input logic [7:0] c, input bit last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{char_code: c, is_last: last};
      do @(posedge clock); while (!req_if.ready);
      predict_char(c, last);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic string random_number();
      string s = "";
      int    ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24)
                                                 : $urandom_range(0, 4);
      int    dot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ndig) : -1;
      for (int i = 0; i < ndig; i++) begin
         if (i == dot_at) s = {s, "."};
         s = {s, string'(8'(aee_pkg::CHAR_0 + $urandom_range(0, 9)))};
      end
      if (dot_at == ndig) s = {s, "."};
      return s;
   endfunction

   // Mostly well-formed expressions; some noise bytes and doubled dots.
   function automatic string random_expression();
      string s = "";
      int    nterms = $urandom_range(1, 4);
      for (int t = 0; t < nterms; t++) begin
         int nfac = $urandom_range(1, 3);
         if (t > 0 || $urandom_range(0, 5) == 0)
            s = {s, ($urandom_range(0, 1) ? "+" : "-")};
         if ($urandom_range(0, 9) == 0) s = {s, ($urandom_range(0, 1) ? "*" : "/")};
         for (int f = 0; f < nfac; f++) begin
            if (f > 0) s = {s, ($urandom_range(0, 1) ? "*" : "/")};
            s = {s, random_number()};
            if ($urandom_range(0, 30) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
            if ($urandom_range(0, 40) == 0) s = {s, ".."};
         end
      end
      if (s.len() == 0) s = "0";
      return s;
   endfunction

   task automatic test_directed();
      send_text("0");
      send_text("9.5");
      send_text("1+2*3-4/8");
      send_text("*5");
      send_text("/4");
      send_text("7/0");
      send_text("7/");
      send_text("1..5");
      send_text("a1");
      send_text("+");
      send_text("-");
      send_text("99999999999999999999999");
      send_text("0.12345678901234567890123");
      send_text("2147483647.9999999999*2");
      send_text("0-2147483648");
      send_text("3/0.0000000001");
      send_text("0.00000000005");
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b1);
      send_text("65536*65536");
      send_text("1.5/0.25*-2");
      wait_drained();
   endtask

   task automatic test_random(input int budget);
      int stop_at = items_sent + budget;
      while (items_sent < stop_at) send_text(random_expression());
   endtask

   task automatic test_backpressure();
      long_hold_pending = 1'b1;
      for (int i = 0; i < 12; i++) send_text("1.5+2*3");
      wait_drained();
   endtask

   task automatic test_noise();
      for (int i = 0; i < 40; i++) begin
         send_char(8'($urandom_range(0, 255)), 1'b0);
         send_char(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // Result side: random stalls, a long hold-off on request, and checking.
   int stall_left = 0;
   int idle_cycles = 0;
   always @(posedge clock) begin
      expected_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value=%h status=%0d", $time,
                     rsp_if.payload.value, rsp_if.payload.status);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_if.payload.value !== e.value) begin
               $display("%0t: value mismatch expected=%h actual=%h", $time,
                        e.value, rsp_if.payload.value);
               error_count++;
            end
            if (rsp_if.payload.status !== e.status) begin
               $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                        e.status, rsp_if.payload.status);
               error_count++;
            end
         end
      end
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL arith_expression_evaluator_top");
         $finish;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      clear_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_noise();
      test_random(1000);
      wait_drained();
      test_random(250);
      quiet = 1'b1;
      test_random(250);
      wait_drained();
      repeat (400) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("PASS arith_expression_evaluator_top");
      else
         $display("FAIL arith_expression_evaluator_top");
      $finish;
   end
endmodule
